[sv/itoa_pkg.sv]
// Shared constants and controller/datapath interface types for the integer to ASCII converter.
`timescale 1ns / 1ps

package itoa_pkg;

    // Operand and decimal digit geometry
    localparam int MAG_W   = 32;
    localparam int NUM_DIG = 10;
    localparam int DIG_W   = 4;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = $clog2(MAG_W);
    localparam int BCD_W   = NUM_DIG * DIG_W;
    localparam int CHAR_W  = 8;
    localparam int TOT_W   = 32;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'd45;
    localparam logic [DIG_W-1:0]  CHAR_DIG_HI = 4'h3;

    // Digit adjust threshold and offset for shift-and-add-3
    localparam logic [DIG_W-1:0] DIG_ADJ_MIN = 4'd5;
    localparam logic [DIG_W-1:0] DIG_ADJ_ADD = 4'd3;

    typedef logic [NUM_DIG-1:0][DIG_W-1:0] bcd_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             shift;
        logic             emit_sign;
        logic             emit_digit;
        logic             last;
        logic [IDX_W-1:0] idx;
    } itoa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic             show_sign;
        logic [IDX_W-1:0] ndig;
        logic             out_free;
    } itoa_sts_t;

endpackage

[sv/int_to_decimal_ascii_top.sv]
// Top level of the signed integer to decimal ASCII converter.
// Each input beat carries a 32-bit two's complement value and a mode bit (0: a minus
// character precedes negative values, 1: magnitude only). The block emits one output beat
// per character, most significant digit first with no leading zeros, marks the final
// character with last_char, and reports on every beat the saturating total of characters
// emitted since reset. An item is taken, converted to BCD by the shift-and-add-3 unit,
// passed through a step that locates the leading digit, and then emits its N characters
// (1 to 11), one character per cycle while the output is not stalled. The input is stalled
// from acceptance until the last character of the item has been loaded into the output
// register.
`timescale 1ns / 1ps

module int_to_decimal_ascii_top
    import itoa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MAG_W-1:0]    value,
    input  logic                func,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CHAR_W-1:0]   ascii_char,
    output logic                last_char,
    output logic [TOT_W-1:0]    total_count
);

    itoa_cmd_t cmd;
    itoa_sts_t sts;

    itoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    itoa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .func        (func),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .ascii_char  (ascii_char),
        .last_char   (last_char),
        .total_count (total_count)
    );

endmodule

[sv/itoa_dp.sv]
// Datapath: magnitude shifter, BCD digit register, output beat register and character counter.
`timescale 1ns / 1ps

module itoa_dp
    import itoa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [MAG_W-1:0]    value,
    input  logic                func,
    input  itoa_cmd_t           cmd,
    output itoa_sts_t           sts,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [CHAR_W-1:0]   ascii_char,
    output logic                last_char,
    output logic [TOT_W-1:0]    total_count
);

    logic [MAG_W-1:0]  mag_reg;
    logic              show_sign_reg;
    bcd_t              bcd_reg;
    bcd_t              adj;
    logic [BCD_W-1:0]  adj_flat;
    logic [BCD_W-1:0]  bcd_next;
    logic [MAG_W-1:0]  mag_in;
    logic              in_neg;
    logic [IDX_W-1:0]  ndig;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic [TOT_W-1:0]  char_total_reg;
    logic              out_free;
    logic              emit;
    logic [CHAR_W-1:0] char_next;

    // Magnitude of the incoming value; the most negative value wraps to its exact magnitude
    assign in_neg = value[MAG_W-1];
    assign mag_in = in_neg ? (~value + {{(MAG_W-1){1'b0}}, 1'b1}) : value;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIG; i++)
        begin
            adj[i] = (bcd_reg[i] >= DIG_ADJ_MIN) ? (bcd_reg[i] + DIG_ADJ_ADD) : bcd_reg[i];
        end
    end

    assign adj_flat = adj;
    assign bcd_next = {adj_flat[BCD_W-2:0], mag_reg[MAG_W-1]};

    // Number of significant digits, at least one
    always_comb
    begin
        ndig = IDX_W'(1);
        for (int i = 1; i < NUM_DIG; i++)
        begin
            if (bcd_reg[i] != '0)
            begin
                ndig = IDX_W'(i + 1);
            end
        end
    end

    // Conversion registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg       <= mag_in;
            show_sign_reg <= in_neg & ~func;
            bcd_reg       <= '0;
        end
        else if (cmd.shift)
        begin
            mag_reg <= {mag_reg[MAG_W-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
    end

    // Output beat register and saturating character total
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign emit      = cmd.emit_sign | cmd.emit_digit;
    assign char_next = cmd.emit_sign ? CHAR_MINUS : {CHAR_DIG_HI, bcd_reg[cmd.idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            char_total_reg <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                if (char_total_reg != '1)
                begin
                    char_total_reg <= char_total_reg + TOT_W'(1);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg <= char_next;
            last_reg <= cmd.last;
        end
    end

    assign sts.show_sign = show_sign_reg;
    assign sts.ndig      = ndig;
    assign sts.out_free  = out_free;

    assign out_valid   = out_valid_reg;
    assign ascii_char  = char_reg;
    assign last_char   = last_reg;
    assign total_count = char_total_reg;

endmodule

[sv/itoa_ctrl.sv]
// Controller: sequences load, binary to BCD shifting, and character emission.
`timescale 1ns / 1ps

module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  itoa_sts_t sts,
    output itoa_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] idx_reg;

    // Commands decoded from the current state
    always_comb
    begin
        cmd            = '0;
        cmd.idx        = idx_reg;
        cmd.load       = (state_reg == ST_IDLE) & in_valid;
        cmd.shift      = (state_reg == ST_CONV);
        cmd.emit_sign  = (state_reg == ST_SIGN) & sts.out_free;
        cmd.emit_digit = (state_reg == ST_EMIT) & sts.out_free;
        cmd.last       = (state_reg == ST_EMIT) & (idx_reg == '0);
    end

    assign in_stall = (state_reg != ST_IDLE);

    // State, shift count and digit index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_valid)
                    begin
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    idx_reg   <= sts.ndig - IDX_W'(1);
                    state_reg <= sts.show_sign ? ST_SIGN : ST_EMIT;
                end
                ST_SIGN:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        if (idx_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/itoa_chk.sv]
// Port-level assertions for the integer to ASCII converter, bound to the top level.
`timescale 1ns / 1ps

module itoa_chk
    import itoa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CHAR_W-1:0] ascii_char,
    input logic              last_char,
    input logic [TOT_W-1:0]  total_count
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ascii_char) && $stable(last_char)
            && $stable(total_count))
        else $error("stalled output beat changed");

    // The block is busy converting right after it takes an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a beat");

    // Only a minus sign or a decimal digit is ever emitted
    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ascii_char == CHAR_MINUS) || (ascii_char >= 8'd48 && ascii_char <= 8'd57))
        else $error("illegal character code");

    // A minus sign never ends a number
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ascii_char == CHAR_MINUS) |-> !last_char)
        else $error("minus sign marked as last character");

    // The character total never goes backwards
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> total_count >= $past(total_count))
        else $error("character total decreased");

endmodule

bind int_to_decimal_ascii_top itoa_chk u_itoa_chk (.*);
